### sv/dht_pkg.sv
// Shared constants, codes and hash folding factors for the double hash table engine.
package dht_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 251;
    localparam int SLOT_W     = 8;
    localparam int KEY_W      = 31;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int STEP_W     = 3;
    localparam int PROBE_W    = 32;
    localparam int CONTENT_W  = 32;

    // Residues of byte weights, used to fold a key down to its home slot
    localparam int FOLD_8  = 256 % TABLE_SIZE;
    localparam int FOLD_16 = 65536 % TABLE_SIZE;
    localparam int FOLD_24 = 16777216 % TABLE_SIZE;

    // Operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;

    // Content reported for an empty slot
    localparam logic [CONTENT_W-1:0] EMPTY_CONTENT = '1;

endpackage

### sv/double_hash_table_engine.sv
// Top level: open-addressing hash table with double hashing over one slot memory.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+------------------------------------------------------
//  request  | i_valid | o_ready | i_op, i_key, i_slot_index
//  result   | o_valid | i_ready | o_status, o_slot_found, o_slot_content,
//           |         |         | o_entry_count, o_probe_total
//
// One item at a time: accept (IDLE), hash fold (HASH1, HASH2), then a memory read and a
// compare (READ, CHECK) per slot visited, then FINISH hands the result to the output register.
// The slot memory read port sets the probe pace.
// Occupancy lives in per-slot valid flops, so reset and clear empty the table at once.
// A stalled result holds in the output register; a new item is taken meanwhile.
module double_hash_table_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_op,
    input  logic [dht_pkg::KEY_W-1:0]           i_key,
    input  logic [dht_pkg::SLOT_W-1:0]          i_slot_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [dht_pkg::SLOT_W-1:0]          o_slot_found,
    output logic signed [dht_pkg::CONTENT_W-1:0] o_slot_content,
    output logic [7:0]                          o_entry_count,
    output logic [dht_pkg::PROBE_W-1:0]         o_probe_total
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_HASH1  = 7'b0000010,
        ST_HASH2  = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_CHECK  = 7'b0010000,
        ST_CLEAR  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    t_state                              r_state, n_state;
    logic [2:0]                          r_op, n_op;
    logic [dht_pkg::KEY_W-1:0]           r_key, n_key;
    logic                                r_in_range, n_in_range;
    logic [dht_pkg::SLOT_W-1:0]          r_idx, n_idx;
    logic [dht_pkg::STEP_W-1:0]          r_step, n_step;
    logic [dht_pkg::CNT_W-1:0]           r_visits, n_visits;
    logic [dht_pkg::CNT_W-1:0]           r_count, n_count;
    logic [dht_pkg::PROBE_W-1:0]         r_probes, n_probes;
    logic [1:0]                          r_status, n_status;
    logic [dht_pkg::SLOT_W-1:0]          r_found, n_found;
    logic [dht_pkg::CONTENT_W-1:0]       r_content, n_content;

    // Hash fold registers
    logic [17:0]                         r_hsum;
    logic [6:0]                          r_oct;
    logic [17:0]                         w_hsum;
    logic [6:0]                          w_oct;

    // Slot memory and occupancy
    logic [dht_pkg::KEY_W-1:0]           r_mem [dht_pkg::TABLE_SIZE];
    logic [dht_pkg::TABLE_SIZE-1:0]      r_slot_valid;
    logic [dht_pkg::KEY_W-1:0]           r_rd_key;
    logic                                r_rd_valid;

    // Output register
    logic                                r_out_valid;
    logic [1:0]                          r_o_status;
    logic [dht_pkg::SLOT_W-1:0]          r_o_found;
    logic [dht_pkg::CONTENT_W-1:0]       r_o_content;
    logic [7:0]                          r_o_count;
    logic [dht_pkg::PROBE_W-1:0]         r_o_probes;

    logic                                w_mem_we;
    logic                                w_valid_set;
    logic                                w_valid_clr;
    logic                                w_clear_all;
    logic                                w_load_out;
    logic                                w_out_free;

    logic [12:0]                         w_fold1;
    logic [8:0]                          w_fold2;
    logic [dht_pkg::SLOT_W-1:0]          w_home;
    logic [3:0]                          w_m1;
    logic [3:0]                          w_m2;
    logic [dht_pkg::STEP_W-1:0]          w_mod7;
    logic [dht_pkg::STEP_W-1:0]          w_step;
    logic [8:0]                          w_next_sum;
    logic [dht_pkg::SLOT_W-1:0]          w_next_idx;
    logic                                w_match;

    // Fold the key: byte residues for the home slot, octal digit sum for mod 7
    always_comb begin
        w_hsum = 18'(int'(r_key[30:24]) * dht_pkg::FOLD_24
                   + int'(r_key[23:16]) * dht_pkg::FOLD_16
                   + int'(r_key[15:8]) * dht_pkg::FOLD_8
                   + int'(r_key[7:0]));
        w_oct = 7'(r_key[30]);
        for (int i = 0; i < 10; i++) begin
            w_oct = w_oct + 7'(r_key[3*i +: 3]);
        end
    end

    // Finish the home slot and the step from the folded sums
    always_comb begin
        w_fold1 = 13'(int'(r_hsum[17:8]) * dht_pkg::FOLD_8 + int'(r_hsum[7:0]));
        w_fold2 = 9'(int'(w_fold1[12:8]) * dht_pkg::FOLD_8 + int'(w_fold1[7:0]));
        w_home  = (w_fold2 >= 9'(dht_pkg::TABLE_SIZE))
                ? dht_pkg::SLOT_W'(w_fold2 - 9'(dht_pkg::TABLE_SIZE))
                : dht_pkg::SLOT_W'(w_fold2);
        w_m1    = 4'(r_oct[6:3]) + 4'(r_oct[2:0]);
        w_m2    = 4'(w_m1[3]) + 4'(w_m1[2:0]);
        w_mod7  = (w_m2 >= 4'd7) ? 3'(w_m2 - 4'd7) : 3'(w_m2);
        w_step  = 3'(4'd7 - 4'(w_mod7));
    end

    // Advance along the probe sequence
    always_comb begin
        w_next_sum = 9'(r_idx) + 9'(r_step);
        w_next_idx = (w_next_sum >= 9'(dht_pkg::TABLE_SIZE))
                   ? dht_pkg::SLOT_W'(w_next_sum - 9'(dht_pkg::TABLE_SIZE))
                   : dht_pkg::SLOT_W'(w_next_sum);
    end

    assign w_match    = r_rd_valid && (r_rd_key == r_key);
    assign w_out_free = !r_out_valid || i_ready;

    // Sequence one item through hash, probe and result
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_in_range = r_in_range;
        n_idx      = r_idx;
        n_step     = r_step;
        n_visits   = r_visits;
        n_count    = r_count;
        n_probes   = r_probes;
        n_status   = r_status;
        n_found    = r_found;
        n_content  = r_content;
        w_mem_we    = 1'b0;
        w_valid_set = 1'b0;
        w_valid_clr = 1'b0;
        w_clear_all = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op       = i_op;
                    n_key      = i_key;
                    n_status   = dht_pkg::STS_OK;
                    n_found    = '0;
                    n_content  = '0;
                    n_in_range = (i_slot_index < dht_pkg::SLOT_W'(dht_pkg::TABLE_SIZE));
                    case (i_op)
                        dht_pkg::OP_INSERT, dht_pkg::OP_REMOVE, dht_pkg::OP_FIND: begin
                            n_state = ST_HASH1;
                        end
                        dht_pkg::OP_READ: begin
                            n_idx    = n_in_range ? i_slot_index : '0;
                            n_visits = dht_pkg::CNT_W'(1);
                            n_state  = ST_READ;
                        end
                        dht_pkg::OP_CLEAR: begin
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_HASH1: begin
                n_state = ST_HASH2;
            end
            ST_HASH2: begin
                n_idx    = w_home;
                n_step   = w_step;
                n_visits = dht_pkg::CNT_W'(1);
                if (r_op == dht_pkg::OP_INSERT
                    && r_count >= dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE)) begin
                    n_status = dht_pkg::STS_FULL;
                    n_state  = ST_FINISH;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                case (r_op)
                    dht_pkg::OP_READ: begin
                        n_content = (r_in_range && r_rd_valid) ? {1'b0, r_rd_key}
                                                              : dht_pkg::EMPTY_CONTENT;
                        n_state   = ST_FINISH;
                    end
                    dht_pkg::OP_INSERT: begin
                        if (!r_rd_valid) begin
                            w_mem_we    = 1'b1;
                            w_valid_set = 1'b1;
                            n_count     = r_count + 1'b1;
                            n_found     = r_idx;
                            n_state     = ST_FINISH;
                        end else begin
                            // count only the home-slot collision
                            if (r_visits == dht_pkg::CNT_W'(1)) begin
                                n_probes = r_probes + 1'b1;
                            end
                            if (r_visits >= dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE)) begin
                                n_status = dht_pkg::STS_FULL;
                                n_state  = ST_FINISH;
                            end else begin
                                n_idx    = w_next_idx;
                                n_visits = r_visits + 1'b1;
                                n_state  = ST_READ;
                            end
                        end
                    end
                    default: begin
                        // remove and find: every visited slot counts
                        n_probes = r_probes + 1'b1;
                        if (w_match) begin
                            n_found = r_idx;
                            if (r_op == dht_pkg::OP_REMOVE) begin
                                w_valid_clr = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                            n_state = ST_FINISH;
                        end else if (!r_rd_valid
                                     || r_visits >= dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE)) begin
                            n_status = dht_pkg::STS_NOT_FOUND;
                            n_state  = ST_FINISH;
                        end else begin
                            n_idx    = w_next_idx;
                            n_visits = r_visits + 1'b1;
                            n_state  = ST_READ;
                        end
                    end
                endcase
            end
            ST_CLEAR: begin
                w_clear_all = 1'b1;
                n_count     = '0;
                n_probes    = '0;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_probes <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_probes <= n_probes;
        end
    end

    // Item payload and working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_in_range <= n_in_range;
        r_idx      <= n_idx;
        r_step     <= n_step;
        r_visits   <= n_visits;
        r_status   <= n_status;
        r_found    <= n_found;
        r_content  <= n_content;
        r_hsum     <= w_hsum;
        r_oct      <= w_oct;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= r_key;
        end
        if (r_state == ST_READ) begin
            r_rd_key   <= r_mem[r_idx];
            r_rd_valid <= r_slot_valid[r_idx];
        end
    end

    // Occupancy bits: drop all on reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (w_clear_all) begin
            r_slot_valid <= '0;
        end else if (w_valid_set) begin
            r_slot_valid[r_idx] <= 1'b1;
        end else if (w_valid_clr) begin
            r_slot_valid[r_idx] <= 1'b0;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_status  <= r_status;
            r_o_found   <= r_found;
            r_o_content <= r_content;
            r_o_count   <= 8'(r_count);
            r_o_probes  <= r_probes;
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_slot_found   = r_o_found;
    assign o_slot_content = r_o_content;
    assign o_entry_count  = r_o_count;
    assign o_probe_total  = r_o_probes;

`ifndef SYNTHESIS
    a_count_tracks_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == int'(r_count))
        else $error("entry count differs from occupied slots");

    a_probe_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_CHECK)
        |-> r_idx < dht_pkg::SLOT_W'(dht_pkg::TABLE_SIZE))
        else $error("probe index beyond table");

    a_visits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK)
        |-> (r_visits != '0 && r_visits <= dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE)))
        else $error("probe walk ran past table size");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> (r_count == '0 && r_probes == '0 && r_slot_valid == '0))
        else $error("clear left state behind");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_op == dht_pkg::OP_INSERT && !r_rd_valid)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert into empty slot did not count");
`endif

endmodule
